// File: sv/ctt_pkg.sv
package ctt_pkg;

    localparam int unsigned VERT_W   = 32;
    localparam int unsigned NORM_W   = 16;
    localparam int unsigned TRIG_W   = 16;
    localparam int unsigned DIV_BITS = 48;
    localparam int unsigned DEN_W    = 32;
    // prep stage plus one stage per quotient bit
    localparam int unsigned DIV_LAT  = DIV_BITS + 1;
    localparam int unsigned DATA_W   = 9 * VERT_W + 3 * NORM_W;
    localparam int unsigned CFG_AW   = 3;
    localparam int unsigned CFG_DW   = 32;

    typedef enum logic [CFG_AW-1:0] {
        REG_CAM_X     = 3'd0,
        REG_CAM_Y     = 3'd1,
        REG_CAM_Z     = 3'd2,
        REG_YAW       = 3'd3,
        REG_PITCH     = 3'd4,
        REG_SCALE     = 3'd5,
        REG_PERSP     = 3'd6,
        REG_UNUSED    = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        SEL_ORTHO = 3'b001,
        SEL_DIV   = 3'b010,
        SEL_ZERO  = 3'b100
    } qsel_t;

    localparam logic [31:0] TRIG_RESET  = 32'h4000_0000;
    localparam logic [31:0] SCALE_RESET = 32'h0001_0000;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -64'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

endpackage

// File: sv/ctt_div.sv
module ctt_div
    import ctt_pkg::*;
(
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [VERT_W-1:0] num_in,
    input  logic signed [VERT_W-1:0] z_in,
    input  logic                     persp,
    output logic signed [VERT_W-1:0] q_out
);

    logic signed [32:0]        d_c;
    logic [DEN_W-1:0]          dmag_c;
    logic [VERT_W-1:0]         nmag_c;
    qsel_t                     sel_c;

    logic [DIV_BITS-1:0]       nq_reg  [DIV_BITS+1];
    logic [DEN_W-1:0]          rem_reg [DIV_BITS+1];
    logic [DEN_W-1:0]          den_reg [DIV_BITS+1];
    logic signed [VERT_W-1:0]  v_reg   [DIV_BITS+1];
    qsel_t                     sel_reg [DIV_BITS+1];
    logic                      sgn_reg [DIV_BITS+1];

    always_comb begin
        d_c    = 33'sd65536 - 33'(z_in);
        dmag_c = d_c[32] ? DEN_W'(-d_c) : d_c[DEN_W-1:0];
        nmag_c = num_in[VERT_W-1] ? VERT_W'(-33'(num_in)) : num_in;
        if (!persp) begin
            sel_c = SEL_ORTHO;
        end else if (d_c == 33'sd0) begin
            sel_c = SEL_ZERO;
        end else begin
            sel_c = SEL_DIV;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nq_reg[0]  <= {nmag_c, 16'b0};
            rem_reg[0] <= '0;
            den_reg[0] <= dmag_c;
            v_reg[0]   <= num_in;
            sel_reg[0] <= sel_c;
            sgn_reg[0] <= num_in[VERT_W-1] ^ d_c[32];
        end
    end

    // one quotient bit per stage, restoring
    for (genvar i = 1; i <= DIV_BITS; i++) begin : g_stage
        logic [DEN_W:0] r2_c;
        logic           ge_c;
        assign r2_c = {rem_reg[i-1], nq_reg[i-1][DIV_BITS-1]};
        assign ge_c = r2_c >= {1'b0, den_reg[i-1]};
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= ge_c ? DEN_W'(r2_c - {1'b0, den_reg[i-1]}) : r2_c[DEN_W-1:0];
                nq_reg[i]  <= {nq_reg[i-1][DIV_BITS-2:0], ge_c};
                den_reg[i] <= den_reg[i-1];
                v_reg[i]   <= v_reg[i-1];
                sel_reg[i] <= sel_reg[i-1];
                sgn_reg[i] <= sgn_reg[i-1];
            end
        end
    end

    always_comb begin
        logic [DIV_BITS-1:0] q;
        logic signed [VERT_W-1:0] v;
        q = nq_reg[DIV_BITS];
        v = v_reg[DIV_BITS];
        unique case (sel_reg[DIV_BITS])
            SEL_ORTHO: q_out = v;
            SEL_ZERO: begin
                if (v > 0) begin
                    q_out = 32'sh7FFF_FFFF;
                end else if (v < 0) begin
                    q_out = 32'sh8000_0000;
                end else begin
                    q_out = '0;
                end
            end
            SEL_DIV: begin
                if (sgn_reg[DIV_BITS]) begin
                    q_out = (q > DIV_BITS'(48'h8000_0000)) ? 32'sh8000_0000
                          : VERT_W'(33'd0 - {1'b0, q[VERT_W-1:0]});
                end else begin
                    q_out = (q > DIV_BITS'(48'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                          : q[VERT_W-1:0];
                end
            end
            default: q_out = '0;
        endcase
    end

endmodule

// File: sv/camera_triangle_transform.sv
// View transform for one triangle per beat.
// s_axis carries three Q16.16 vertices and a Q2.14 face normal; m_axis
// returns projected x/y and rotated depth per vertex plus the rotated normal.
// The cfg port writes the camera registers; write only while no beat is
// in flight.
// Throughput: one triangle per cycle while the output is not stalled. The
// pipeline is 5 stages of translate and rotate,
// a 49-stage perspective divider (one quotient bit per stage), a scale
// multiply stage and the output register.
// Reset clears all valid bits and loads the camera registers with their
// defaults (identity rotation, unit scale, orthographic).
// When m_axis_tready is low with a valid output, the whole pipeline holds
// and s_axis_tready drops; nothing is lost or repeated.
module camera_triangle_transform
    import ctt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // vert_ax, vert_ay, vert_az, vert_bx, vert_by, vert_bz,
    // vert_cx, vert_cy, vert_cz, norm_in_x, norm_in_y, norm_in_z
    input  logic [DATA_W-1:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // proj_ax, proj_ay, depth_a, proj_bx, proj_by, depth_b,
    // proj_cx, proj_cy, depth_c, norm_out_x, norm_out_y, norm_out_z
    output logic [DATA_W-1:0] m_axis_tdata,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata
);

    typedef struct packed {
        logic [2:0][VERT_W-1:0] depth;
        logic [2:0][NORM_W-1:0] norm;
    } side_t;

    logic signed [VERT_W-1:0] cam_reg [3];
    logic [31:0]              yaw_reg, pitch_reg;
    logic signed [VERT_W-1:0] scale_reg;
    logic                     persp_reg;

    logic en;
    logic signed [TRIG_W-1:0] cy, sy, cp, sp;

    logic                     v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, vo_reg;
    logic                     vd_reg [DIV_LAT];
    side_t                    sd_reg [DIV_LAT];

    logic signed [VERT_W-1:0] t_reg  [3][3];
    logic signed [NORM_W-1:0] n1_reg [3];
    logic signed [47:0]       pxc_reg [3], pzs_reg [3], pzc_reg [3], pxs_reg [3];
    logic signed [VERT_W-1:0] y2c_reg [3];
    logic signed [31:0]       nxc_reg, nzs_reg, nzc_reg, nxs_reg;
    logic signed [NORM_W-1:0] ny2_reg;
    logic signed [VERT_W-1:0] x1_reg [3], z1_reg [3], y3_reg [3];
    logic signed [NORM_W-1:0] nx1_reg, nz1_reg, ny3_reg;
    logic signed [47:0]       pyc_reg [3], pzsp_reg [3], pysp_reg [3], pzcp_reg [3];
    logic signed [VERT_W-1:0] x4_reg [3];
    logic signed [31:0]       nyc_reg, nzsp_reg, nysp_reg, nzcp_reg;
    logic signed [NORM_W-1:0] nx4_reg;
    logic signed [VERT_W-1:0] x5_reg [3], y5_reg [3], z5_reg [3];
    logic signed [NORM_W-1:0] no5_reg [3];
    logic signed [VERT_W-1:0] q_c [3][2];
    logic signed [63:0]       pm_reg [3][2];
    side_t                    s6_reg;
    logic [DATA_W-1:0]        out_reg;

    assign cy = yaw_reg[31:16];
    assign sy = yaw_reg[15:0];
    assign cp = pitch_reg[31:16];
    assign sp = pitch_reg[15:0];

    assign en            = !vo_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vo_reg;
    assign m_axis_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_reg[0] <= '0;
            cam_reg[1] <= '0;
            cam_reg[2] <= '0;
            yaw_reg    <= TRIG_RESET;
            pitch_reg  <= TRIG_RESET;
            scale_reg  <= SCALE_RESET;
            persp_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_addr))
                REG_CAM_X:  cam_reg[0] <= cfg_wdata;
                REG_CAM_Y:  cam_reg[1] <= cfg_wdata;
                REG_CAM_Z:  cam_reg[2] <= cfg_wdata;
                REG_YAW:    yaw_reg    <= cfg_wdata;
                REG_PITCH:  pitch_reg  <= cfg_wdata;
                REG_SCALE:  scale_reg  <= cfg_wdata;
                REG_PERSP:  persp_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            vo_reg <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++) vd_reg[i] <= 1'b0;
        end else if (en) begin
            v1_reg    <= s_axis_tvalid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            vd_reg[0] <= v5_reg;
            for (int i = 1; i < DIV_LAT; i++) vd_reg[i] <= vd_reg[i-1];
            v6_reg    <= vd_reg[DIV_LAT-1];
            vo_reg    <= v6_reg;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_vert
        always_ff @(posedge aclk) begin
            if (en) begin
                // translate
                for (int c = 0; c < 3; c++) begin
                    t_reg[k][c] <= sat32(64'(signed'(s_axis_tdata[(3*k+c)*VERT_W +: VERT_W]))
                                        - 64'(cam_reg[c]));
                end
                // yaw products
                pxc_reg[k] <= 48'(t_reg[k][0]) * 48'(cy);
                pzs_reg[k] <= 48'(t_reg[k][2]) * 48'(sy);
                pzc_reg[k] <= 48'(t_reg[k][2]) * 48'(cy);
                pxs_reg[k] <= 48'(t_reg[k][0]) * 48'(sy);
                y2c_reg[k] <= t_reg[k][1];
                // yaw sums
                x1_reg[k] <= sat32(64'((49'(pxc_reg[k]) + 49'(pzs_reg[k])) >>> 14));
                z1_reg[k] <= sat32(64'((49'(pzc_reg[k]) - 49'(pxs_reg[k])) >>> 14));
                y3_reg[k] <= y2c_reg[k];
                // pitch products
                pyc_reg[k]  <= 48'(y3_reg[k]) * 48'(cp);
                pzsp_reg[k] <= 48'(z1_reg[k]) * 48'(sp);
                pysp_reg[k] <= 48'(y3_reg[k]) * 48'(sp);
                pzcp_reg[k] <= 48'(z1_reg[k]) * 48'(cp);
                x4_reg[k]   <= x1_reg[k];
                // pitch sums
                x5_reg[k] <= x4_reg[k];
                y5_reg[k] <= sat32(64'((49'(pyc_reg[k]) - 49'(pzsp_reg[k])) >>> 14));
                z5_reg[k] <= sat32(64'((49'(pysp_reg[k]) + 49'(pzcp_reg[k])) >>> 14));
                // scale
                pm_reg[k][0] <= 64'(q_c[k][0]) * 64'(scale_reg);
                pm_reg[k][1] <= 64'(q_c[k][1]) * 64'(scale_reg);
            end
        end

        ctt_div u_div_x (
            .aclk   (aclk),
            .en     (en),
            .num_in (x5_reg[k]),
            .z_in   (z5_reg[k]),
            .persp  (persp_reg),
            .q_out  (q_c[k][0])
        );

        ctt_div u_div_y (
            .aclk   (aclk),
            .en     (en),
            .num_in (y5_reg[k]),
            .z_in   (z5_reg[k]),
            .persp  (persp_reg),
            .q_out  (q_c[k][1])
        );
    end

    // normal: rotate only
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                n1_reg[c] <= s_axis_tdata[9*VERT_W + c*NORM_W +: NORM_W];
            end
            nxc_reg  <= 32'(n1_reg[0]) * 32'(cy);
            nzs_reg  <= 32'(n1_reg[2]) * 32'(sy);
            nzc_reg  <= 32'(n1_reg[2]) * 32'(cy);
            nxs_reg  <= 32'(n1_reg[0]) * 32'(sy);
            ny2_reg  <= n1_reg[1];
            nx1_reg  <= sat16(64'((33'(nxc_reg) + 33'(nzs_reg)) >>> 14));
            nz1_reg  <= sat16(64'((33'(nzc_reg) - 33'(nxs_reg)) >>> 14));
            ny3_reg  <= ny2_reg;
            nyc_reg  <= 32'(ny3_reg) * 32'(cp);
            nzsp_reg <= 32'(nz1_reg) * 32'(sp);
            nysp_reg <= 32'(ny3_reg) * 32'(sp);
            nzcp_reg <= 32'(nz1_reg) * 32'(cp);
            nx4_reg  <= nx1_reg;
            no5_reg[0] <= nx4_reg;
            no5_reg[1] <= sat16(64'((33'(nyc_reg) - 33'(nzsp_reg)) >>> 14));
            no5_reg[2] <= sat16(64'((33'(nysp_reg) + 33'(nzcp_reg)) >>> 14));
        end
    end

    // carry depth and normal alongside the divider
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                sd_reg[0].depth[k] <= z5_reg[k];
                sd_reg[0].norm[k]  <= no5_reg[k];
            end
            for (int i = 1; i < DIV_LAT; i++) sd_reg[i] <= sd_reg[i-1];
            s6_reg <= sd_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                out_reg[(3*k)*VERT_W +: VERT_W]   <= sat32(pm_reg[k][0] >>> 16);
                out_reg[(3*k+1)*VERT_W +: VERT_W] <= sat32(pm_reg[k][1] >>> 16);
                out_reg[(3*k+2)*VERT_W +: VERT_W] <= s6_reg.depth[k];
                out_reg[9*VERT_W + k*NORM_W +: NORM_W] <= s6_reg.norm[k];
            end
        end
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb
    import ctt_pkg::*;
();

    typedef logic signed [31:0] q16_t;
    typedef logic signed [15:0] q14_t;

    typedef struct {
        q16_t v[9];
        q14_t n[3];
    } tri_t;

    // camera registers as seen by the predictor
    typedef struct {
        q16_t cam[3];
        logic [31:0] yaw;
        logic [31:0] pitch;
        q16_t scale;
        logic persp;
    } cam_cfg_t;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint proj_coord(cam_cfg_t c, longint v, longint z);
        longint q;
        longint d;
        q = v;
        if (c.persp) begin
            d = 65536 - z;
            if (d == 0) q = (v > 0) ? 64'sd2147483647 : ((v < 0) ? -64'sd2147483648 : 0);
            else q = clamp32((v * 65536) / d);
        end
        return clamp32((q * longint'(c.scale)) >>> 16);
    endfunction

    function automatic logic [DATA_W-1:0] view_transform(cam_cfg_t c, tri_t t);
        logic [DATA_W-1:0] r;
        longint cy, sy, cp, sp, x, y, z, x1, z1, y2, z2, nx, ny, nz, nx1, nz1;
        cy = longint'($signed(c.yaw[31:16]));
        sy = longint'($signed(c.yaw[15:0]));
        cp = longint'($signed(c.pitch[31:16]));
        sp = longint'($signed(c.pitch[15:0]));
        r = '0;
        for (int k = 0; k < 3; k++) begin
            x = clamp32(longint'(t.v[3*k]) - longint'(c.cam[0]));
            y = clamp32(longint'(t.v[3*k+1]) - longint'(c.cam[1]));
            z = clamp32(longint'(t.v[3*k+2]) - longint'(c.cam[2]));
            x1 = clamp32((x * cy + z * sy) >>> 14);
            z1 = clamp32((z * cy - x * sy) >>> 14);
            y2 = clamp32((y * cp - z1 * sp) >>> 14);
            z2 = clamp32((y * sp + z1 * cp) >>> 14);
            r[96*k +: 32] = 32'(proj_coord(c, x1, z2));
            r[96*k+32 +: 32] = 32'(proj_coord(c, y2, z2));
            r[96*k+64 +: 32] = 32'(z2);
        end
        nx = longint'(t.n[0]);
        ny = longint'(t.n[1]);
        nz = longint'(t.n[2]);
        nx1 = clamp16((nx * cy + nz * sy) >>> 14);
        nz1 = clamp16((nz * cy - nx * sy) >>> 14);
        r[288 +: 16] = 16'(nx1);
        r[304 +: 16] = 16'(clamp16((ny * cp - nz1 * sp) >>> 14));
        r[320 +: 16] = 16'(clamp16((ny * sp + nz1 * cp) >>> 14));
        return r;
    endfunction

    class triangle_board;
        logic [DATA_W-1:0] pending[$];
        int errors;

        function void note_triangle(cam_cfg_t c, tri_t t);
            pending.push_back(view_transform(c, t));
        endfunction

        function void check_beat(logic [DATA_W-1:0] got);
            logic [DATA_W-1:0] exp;
            string names[12];
            logic [31:0] gf, ef;
            names = '{"proj_ax", "proj_ay", "depth_a", "proj_bx", "proj_by", "depth_b",
                      "proj_cx", "proj_cy", "depth_c", "norm_out_x", "norm_out_y",
                      "norm_out_z"};
            if (pending.size() == 0) begin
                $error("unexpected output beat %h", got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            for (int f = 0; f < 12; f++) begin
                if (f < 9) begin
                    gf = got[32*f +: 32];
                    ef = exp[32*f +: 32];
                end else begin
                    gf = 32'(got[288 + 16*(f-9) +: 16]);
                    ef = 32'(exp[288 + 16*(f-9) +: 16]);
                end
                if (gf != ef) begin
                    $error("%s: expected %h, got %h", names[f], ef, gf);
                    errors++;
                end
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [DATA_W-1:0] m_axis_tdata;
    logic cfg_we;
    logic [CFG_AW-1:0] cfg_addr;
    logic [CFG_DW-1:0] cfg_wdata;

    camera_triangle_transform uut (.*);

    triangle_board board;
    cam_cfg_t cfg;
    int hold_off_cycles;
    longint cycles;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > 400000) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // check output beats at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) board.check_beat(m_axis_tdata);
    end

    // receiver stalls on its own pattern, with one long hold-off
    initial begin
        int phase;
        m_axis_tready = 1'b0;
        phase = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_cycles > 0) begin
                m_axis_tready <= 1'b0;
                hold_off_cycles--;
            end else begin
                phase = (phase + 1) % 400;
                if (phase < 100) m_axis_tready <= 1'b1;
                else m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_CAM_X: cfg.cam[0] = val;
            REG_CAM_Y: cfg.cam[1] = val;
            REG_CAM_Z: cfg.cam[2] = val;
            REG_YAW:   cfg.yaw = val;
            REG_PITCH: cfg.pitch = val;
            REG_SCALE: cfg.scale = val;
            REG_PERSP: cfg.persp = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (70) @(negedge aclk);
    endtask

    // present a triangle at the falling edge, hold until accepted
    task automatic send_triangle(tri_t t);
        logic [DATA_W-1:0] d;
        for (int k = 0; k < 9; k++) d[32*k +: 32] = t.v[k];
        for (int k = 0; k < 3; k++) d[288+16*k +: 16] = t.n[k];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        do @(posedge aclk); while (!s_axis_tready);
        board.note_triangle(cfg, t);
        @(negedge aclk);
    endtask

    function automatic q16_t pick_coord(int mode);
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2, 3: return $urandom();
            default: return $signed($urandom_range(0, 20 << 16)) - (10 << 16) >>> mode;
        endcase
    endfunction

    function automatic tri_t random_triangle(int mode);
        tri_t t;
        for (int k = 0; k < 9; k++) t.v[k] = pick_coord(mode);
        // occasionally put a vertex at translated depth exactly one
        if (cfg.persp && $urandom_range(0, 15) == 0) begin
            t.v[0] = cfg.cam[0];
            t.v[1] = cfg.cam[1];
            t.v[2] = 32'sd65536 + cfg.cam[2];
        end
        for (int k = 0; k < 3; k++) t.n[k] = 16'($urandom());
        return t;
    endfunction

    task automatic random_phase(int count);
        int burst;
        int sent;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst && sent < count; i++) begin
                send_triangle(random_triangle($urandom_range(0, 8)));
                sent++;
            end
            if ($urandom_range(0, 2) == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        tri_t t;
        logic [31:0] trig[6];
        board = new();
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_addr = REG_CAM_X;
        cfg_wdata = '0;
        hold_off_cycles = 0;
        aresetn = 1'b0;
        cfg.cam = '{0, 0, 0};
        cfg.yaw = TRIG_RESET;
        cfg.pitch = TRIG_RESET;
        cfg.scale = SCALE_RESET;
        cfg.persp = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes under reset settings
        for (int i = 0; i < 6; i++) begin
            for (int k = 0; k < 9; k++)
                t.v[k] = (i == 0) ? 32'sh7FFF_FFFF : (i == 1) ? 32'sh8000_0000 :
                         (i == 2) ? 0 : (i == 3) ? -1 : $urandom();
            for (int k = 0; k < 3; k++)
                t.n[k] = (i == 0) ? 16'sh7FFF : (i == 1) ? 16'sh8000 : 16'($urandom());
            send_triangle(t);
        end
        s_axis_tvalid <= 1'b0;
        drain();

        // directed: perspective with depth exactly one, v positive, negative, zero
        write_reg(REG_PERSP, 32'hFFFF_FFFF);
        write_reg(REG_UNUSED, 32'h1234_5678);
        t.v = '{32'sd5 << 16, -(32'sd3 << 16), 32'sd65536, 0, 0, 32'sd65536,
                -(32'sd7 << 16), 32'sd9 << 16, 32'sd65536};
        t.n = '{16'sh4000, 16'sh0, 16'sh0};
        send_triangle(t);
        t.v = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd65535, 32'sd1, -1, 32'sd65537,
                32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
        send_triangle(t);
        s_axis_tvalid <= 1'b0;
        drain();

        // setting sweep including extremes
        trig = '{32'h2D41_2D41, 32'h7FFF_8000, 32'h8000_7FFF, 32'h0000_4000,
                 32'hC000_0000, 32'h3B21_E783};
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(REG_CAM_X, (ph == 0) ? 32'h7FFF_FFFF : (ph == 1) ? 32'h8000_0000 :
                      $urandom_range(0, 1 << 20) - (1 << 19));
            write_reg(REG_CAM_Y, (ph == 1) ? 32'h7FFF_FFFF : (ph == 0) ? 32'h8000_0000 :
                      $urandom_range(0, 1 << 20) - (1 << 19));
            write_reg(REG_CAM_Z, (ph == 2) ? 32'h8000_0000 : (ph == 3) ? 32'h7FFF_FFFF :
                      $urandom_range(0, 1 << 20) - (1 << 19));
            write_reg(REG_YAW, (ph < 6) ? trig[ph] : $urandom());
            write_reg(REG_PITCH, (ph < 6) ? trig[5 - ph] : $urandom());
            write_reg(REG_SCALE, (ph == 4) ? 32'h7FFF_FFFF : (ph == 5) ? 32'h8000_0000 :
                      (ph == 6) ? 32'h0 : $urandom_range(1 << 15, 1 << 19));
            write_reg(REG_PERSP, 32'(ph[0]));
            if (ph == 3) begin
                // long receiver hold-off while the sender keeps offering
                hold_off_cycles = 300;
            end
            random_phase(190);
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: files.f
sv/ctt_pkg.sv
sv/ctt_div.sv
sv/camera_triangle_transform.sv
dv/tb.sv
